// File: src/sfd_pkg.sv
// Shared types and constants of the signed floor divider.
// No dependencies; every other file imports it.
package sfd_pkg;

  localparam int unsigned DIVIDEND_WIDTH = 32;
  localparam int unsigned DIVISOR_WIDTH  = 32;

  localparam int unsigned SFD_STEP_BITS = 2;
  localparam int unsigned SFD_STAGES    = (DIVIDEND_WIDTH + SFD_STEP_BITS - 1) / SFD_STEP_BITS;
  localparam int unsigned SFD_QD_WIDTH  = SFD_STAGES * SFD_STEP_BITS;

  typedef enum logic [1:0] {
    SFD_OK       = 2'd0,
    SFD_UNKNOWN  = 2'd1,
    SFD_DIV_ZERO = 2'd2
  } sfd_status_e;

  typedef struct packed {
    sfd_status_e              status;
    logic                     nx;
    logic                     ny;
    logic [DIVISOR_WIDTH-1:0] ay;
    logic [DIVISOR_WIDTH-1:0] rem;
    logic [SFD_QD_WIDTH-1:0]  qd;
  } sfd_pipe_t;

endpackage

// File: src/sfd_if.sv
// Operand and result channels of the signed floor divider.
// Depends on sfd_pkg.
interface sfd_in_if import sfd_pkg::*; ();
  logic                              valid;
  logic                              ready;
  logic signed [DIVIDEND_WIDTH-1:0] dividend;
  logic                              dividend_known;
  logic signed [DIVISOR_WIDTH-1:0]  divisor;
  logic                              divisor_known;

  modport source (output valid, dividend, dividend_known, divisor, divisor_known,
                  input ready);
  modport sink   (input valid, dividend, dividend_known, divisor, divisor_known,
                  output ready);
endinterface

interface sfd_out_if import sfd_pkg::*; ();
  logic                              valid;
  logic                              ready;
  sfd_status_e                       status;
  logic signed [DIVIDEND_WIDTH-1:0] quotient;
  logic                              quotient_valid;
  logic signed [DIVISOR_WIDTH-1:0]  remainder;
  logic                              remainder_valid;

  modport source (output valid, status, quotient, quotient_valid, remainder,
                  remainder_valid, input ready);
  modport sink   (input valid, status, quotient, quotient_valid, remainder,
                  remainder_valid, output ready);
endinterface

// File: src/sfd_prep.sv
// Input stage: classifies the operand beat and takes magnitudes.
// Depends on sfd_pkg and sfd_in_if.
module sfd_prep import sfd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  sfd_in_if.sink          in_i,
  output logic            valid_o,
  input  logic            ready_i,
  output sfd_pipe_t       data_o
);

  logic                      valid_q;
  sfd_pipe_t                 data_q;
  sfd_pipe_t                 data_d;
  logic [DIVIDEND_WIDTH-1:0] x;
  logic [DIVISOR_WIDTH-1:0]  y;
  logic [DIVIDEND_WIDTH-1:0] ax;

  assign in_i.ready = !valid_q || ready_i;

  always_comb begin
    x  = in_i.dividend;
    y  = in_i.divisor;
    ax = x[DIVIDEND_WIDTH-1] ? (~x + 1'b1) : x;
    data_d.nx  = x[DIVIDEND_WIDTH-1];
    data_d.ny  = y[DIVISOR_WIDTH-1];
    data_d.ay  = y[DIVISOR_WIDTH-1] ? (~y + 1'b1) : y;
    data_d.rem = '0;
    data_d.qd  = SFD_QD_WIDTH'(ax);
    priority if (!in_i.dividend_known || !in_i.divisor_known) begin
      data_d.status = SFD_UNKNOWN;
    end else if (y == '0) begin
      data_d.status = SFD_DIV_ZERO;
    end else begin
      data_d.status = SFD_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/sfd_step.sv
// One divider stage: restoring division over SFD_STEP_BITS quotient bits.
// Depends on sfd_pkg.
module sfd_step import sfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  sfd_pipe_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output sfd_pipe_t data_o
);

  logic                       valid_q;
  sfd_pipe_t                  data_q;
  sfd_pipe_t                  data_d;
  logic [DIVISOR_WIDTH:0]     shifted;
  logic [DIVISOR_WIDTH+1:0]   diff;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d  = data_i;
    shifted = '0;
    diff    = '0;
    for (int k = 0; k < SFD_STEP_BITS; k++) begin
      shifted = {data_d.rem, data_d.qd[SFD_QD_WIDTH-1]};
      diff    = {1'b0, shifted} - {2'b00, data_d.ay};
      if (diff[DIVISOR_WIDTH+1]) begin
        data_d.rem = shifted[DIVISOR_WIDTH-1:0];
      end else begin
        data_d.rem = diff[DIVISOR_WIDTH-1:0];
      end
      data_d.qd = {data_d.qd[SFD_QD_WIDTH-2:0], ~diff[DIVISOR_WIDTH+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/sfd_fix.sv
// Output stage: floor correction of the signs and the result register.
// Depends on sfd_pkg and sfd_out_if.
module sfd_fix import sfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  sfd_pipe_t data_i,
  sfd_out_if.source out_o
);

  logic                      valid_q;
  sfd_status_e               status_q;
  logic [DIVIDEND_WIDTH-1:0] quot_q, quot_d;
  logic [DIVISOR_WIDTH-1:0]  rem_q, rem_d;
  logic                      res_ok_q;
  logic [DIVIDEND_WIDTH-1:0] qmag;
  logic                      rem_nz;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    qmag   = data_i.qd[DIVIDEND_WIDTH-1:0];
    rem_nz = (data_i.rem != '0);
    quot_d = '0;
    rem_d  = '0;
    if (data_i.status == SFD_OK) begin
      priority if (data_i.nx != data_i.ny && rem_nz) begin
        quot_d = ~qmag;
        rem_d  = data_i.ny ? (data_i.rem - data_i.ay) : (data_i.ay - data_i.rem);
      end else if (data_i.nx != data_i.ny) begin
        quot_d = ~qmag + 1'b1;
      end else begin
        quot_d = qmag;
        rem_d  = data_i.nx ? (~data_i.rem + 1'b1) : data_i.rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      status_q <= data_i.status;
      quot_q   <= quot_d;
      rem_q    <= rem_d;
      res_ok_q <= (data_i.status == SFD_OK);
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.status          = status_q;
  assign out_o.quotient        = quot_q;
  assign out_o.quotient_valid  = res_ok_q;
  assign out_o.remainder       = rem_q;
  assign out_o.remainder_valid = res_ok_q;

endmodule

// File: src/signed_floor_divider_unit.sv
// Top level of the signed floor divider: input stage, divider stages, output stage.
// Depends on sfd_pkg, sfd_if, sfd_prep, sfd_step and sfd_fix.
//
//   channel | direction | beat contents
//   in_i    | in        | dividend, dividend_known, divisor, divisor_known
//   out_o   | out       | status, quotient, quotient_valid, remainder, remainder_valid
//
// One beat in and one beat out per cycle when neither side stalls.
// The stages are one input stage, one stage per SFD_STEP_BITS quotient bits
// of the restoring divider, and one output stage.
// Each stage holds its beat while the next one stalls; empty stages fill regardless.
// Reset clears only the stage valid bits.
module signed_floor_divider_unit import sfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfd_in_if.sink    in_i,
  sfd_out_if.source out_o
);

  sfd_pipe_t pipe  [SFD_STAGES+1];
  logic      valid [SFD_STAGES+1];
  logic      ready [SFD_STAGES+1];

  sfd_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .data_o  (pipe[0])
  );

  for (genvar s = 0; s < SFD_STAGES; s++) begin : g_step
    sfd_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[s]),
      .ready_o (ready[s]),
      .data_i  (pipe[s]),
      .valid_o (valid[s+1]),
      .ready_i (ready[s+1]),
      .data_o  (pipe[s+1])
    );
  end

  sfd_fix u_fix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[SFD_STAGES]),
    .ready_o (ready[SFD_STAGES]),
    .data_i  (pipe[SFD_STAGES]),
    .out_o   (out_o)
  );

endmodule
